[rtl/mbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int OFFSET_BITS       = 32;
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_IDX_W         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int MATCH_OFFSET_W    = 32;
    localparam int PATTERN_BYTES     = 16;

    typedef logic [7:0] byte_t;
    typedef byte_t [MAX_PATTERN_BYTES-1:0] window_t;
    typedef byte_t [PATTERN_BYTES-1:0] pattern_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALUE_LOW   = 3'd0,
        CFG_VALUE_HIGH  = 3'd1,
        CFG_MASK_LOW    = 3'd2,
        CFG_MASK_HIGH   = 3'd3,
        CFG_LENGTH      = 3'd4,
        CFG_STRIDE      = 3'd5,
        CFG_START_PHASE = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        STRIDE_ANY     = 2'd0,
        STRIDE_FOUR    = 2'd1,
        STRIDE_SIXTEEN = 2'd2
    } stride_t;

endpackage

[rtl/mbps_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_channels
// Valid/ready channels of the scanner: buffer bytes in, scan results out.
// ----------------------------------------------------------------------------
interface mbps_in_if
    import mbps_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if
    import mbps_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[rtl/masked_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams buffer bytes through a sliding window and reports the first
// aligned start position where the masked pattern matches.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on in_ch, one per transfer; last_byte marks the end of a
//   buffer. Each buffer yields at most one transfer on out_ch: found with
//   the offset of the first match, or not-found on the last byte. Bytes
//   after a match are consumed without a result until the buffer ends.
//   The pattern (values, masks, length), stride and start phase are set
//   through the write port while no byte is in flight.
// Timing:
//   A byte is taken into an input register, compared against the window
//   once the output slot is free, and its result, if any, lands in the
//   output register. One byte per cycle is sustained while the receiver
//   does not stall; the masked compare of the pattern against the window
//   is combinational.
// Reset and stalls:
//   Reset clears the registers to their defaults (length one, any
//   stride) and empties the window and both pipeline registers. When the
//   receiver stalls, the result is held and the byte in the input
//   register waits; in_ch.ready drops only while both are occupied.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mbps_in_if.sink                in_ch,
    mbps_out_if.source             out_ch
);

    // Configuration registers.
    logic [63:0]      value_low_reg;
    logic [63:0]      value_high_reg;
    logic [63:0]      mask_low_reg;
    logic [63:0]      mask_high_reg;
    logic [4:0]       length_reg;
    logic [1:0]       stride_reg;
    logic [3:0]       phase_reg;

    // Input stage.
    logic             in_valid_reg;
    byte_t            in_data_reg;
    logic             in_last_reg;

    // Scan state.
    window_t                window_reg;
    logic [OFFSET_BITS-1:0] byte_count_reg;
    logic [LEN_W-1:0]       window_fill_reg;
    logic                   match_reported_reg;

    // Output stage.
    logic                      out_valid_reg;
    logic                      found_reg;
    logic [MATCH_OFFSET_W-1:0] offset_reg;

    logic                   out_free;
    logic                   proceed;
    window_t                window_next;
    logic [LEN_W-1:0]       window_fill_next;
    logic [LEN_W-1:0]       len;
    logic [OFFSET_BITS-1:0] start;
    logic [3:0]             addr;
    logic [3:0]             stride_mask;
    logic                   pattern_hit;
    logic                   match;
    logic                   produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_low_reg  <= '0;
            value_high_reg <= '0;
            mask_low_reg   <= '0;
            mask_high_reg  <= '0;
            length_reg     <= 5'd1;
            stride_reg     <= 2'd0;
            phase_reg      <= 4'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_VALUE_LOW:   value_low_reg  <= cfg_data;
                CFG_VALUE_HIGH:  value_high_reg <= cfg_data;
                CFG_MASK_LOW:    mask_low_reg   <= cfg_data;
                CFG_MASK_HIGH:   mask_high_reg  <= cfg_data;
                CFG_LENGTH:      length_reg     <= cfg_data[4:0];
                CFG_STRIDE:      stride_reg     <= cfg_data[1:0];
                CFG_START_PHASE: phase_reg      <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // The output slot is free when empty or when its result leaves now.
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign proceed      = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || proceed;

    // A length of zero counts as one; longer than the window is clipped.
    always_comb
    begin
        if (length_reg == 5'd0)
        begin
            len = LEN_W'(1);
        end
        else if (32'(length_reg) > MAX_PATTERN_BYTES)
        begin
            len = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len = LEN_W'(length_reg);
        end
    end

    // Stride code three behaves as any byte.
    always_comb
    begin
        unique case (stride_reg)
            STRIDE_FOUR:    stride_mask = 4'h3;
            STRIDE_SIXTEEN: stride_mask = 4'hF;
            default:        stride_mask = 4'h0;
        endcase
    end

    // Window after shifting in the byte of the input stage.
    always_comb
    begin
        window_next[0] = in_data_reg;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    assign window_fill_next = (32'(window_fill_reg) < MAX_PATTERN_BYTES)
                              ? window_fill_reg + LEN_W'(1) : window_fill_reg;

    // Candidate start: byte_count + 1 - len, wrapping at the offset width.
    assign start = byte_count_reg + OFFSET_BITS'(1) - OFFSET_BITS'(len);
    assign addr  = start[3:0] + phase_reg;

    mbps_match u_match (
        .window    (window_next),
        .pat_value (pattern_t'({value_high_reg, value_low_reg})),
        .pat_mask  (pattern_t'({mask_high_reg, mask_low_reg})),
        .len       (len),
        .hit       (pattern_hit)
    );

    assign match   = (window_fill_next >= len) && ((addr & stride_mask) == 4'h0)
                     && pattern_hit;
    assign produce = !match_reported_reg && (match || in_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_data_reg <= in_ch.data_byte;
            in_last_reg <= in_ch.last_byte;
        end
    end

    // The window only moves until a match is reported for this buffer.
    always_ff @(posedge clk)
    begin
        if (proceed && !match_reported_reg)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            window_fill_reg    <= '0;
            match_reported_reg <= 1'b0;
        end
        else if (proceed)
        begin
            if (in_last_reg)
            begin
                byte_count_reg     <= '0;
                window_fill_reg    <= '0;
                match_reported_reg <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_reg + OFFSET_BITS'(1);
                if (!match_reported_reg)
                begin
                    window_fill_reg <= window_fill_next;
                    if (match)
                    begin
                        match_reported_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && produce)
        begin
            found_reg  <= match;
            offset_reg <= match ? MATCH_OFFSET_W'(start) : '0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.match_offset = offset_reg;

    // A not-found result always carries a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> offset_reg == '0)
        else $error("not-found result with nonzero offset");

    // The fill count never passes the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(window_fill_reg) <= MAX_PATTERN_BYTES)
        else $error("window fill count overflow");

    // The end of a buffer restarts the scan state.
    assert property (@(posedge clk) disable iff (!rst_n)
        proceed && in_last_reg |=>
            byte_count_reg == '0 && window_fill_reg == '0 && !match_reported_reg)
        else $error("scan state not cleared after last byte");

    // A byte waiting behind a stalled result stays in the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a byte during a stall");

    // A result produced while the output slot is free is registered in it.
    assert property (@(posedge clk) disable iff (!rst_n)
        proceed && produce |=> out_valid_reg)
        else $error("result was not registered");

endmodule

[rtl/mbps_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the pattern against the newest bytes of the window.
// ----------------------------------------------------------------------------
module mbps_match
    import mbps_pkg::*;
(
    input  window_t            window,
    input  pattern_t           pat_value,
    input  pattern_t           pat_mask,
    input  logic [LEN_W-1:0]   len,
    output logic               hit
);

    // Pattern byte j lines up with window position len-1-j; index 0 is newest.
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        byte_t            b;
        hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            idx = len - LEN_W'(j + 1);
            b   = window[idx[WIN_IDX_W-1:0]];
            if (LEN_W'(j) < len)
            begin
                if ((b & pat_mask[j]) != (pat_value[j] & pat_mask[j]))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule
